### rtl/p2f_pkg.sv
package p2f_pkg;

  localparam int DIGITS   = 5;
  localparam int NCHARS   = 2 * DIGITS;
  localparam int PERIOD_W = 16;
  localparam int REF_W    = 26;
  localparam int CHAR_W   = 6;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int CNT_W    = $clog2(NCHARS);

  localparam logic [REF_W-1:0]    REF_RESET  = REF_W'(16000000);
  localparam logic [PERIOD_W-1:0] FREQ_MAX   = {PERIOD_W{1'b1}};
  localparam logic [CHAR_W-1:0]   ASCII_ZERO = CHAR_W'(8'h30);

  typedef struct packed {
    logic [REF_W-1:0]    dvd;
    logic [REF_W-1:0]    quo;
    logic [PERIOD_W-1:0] rem;
    logic [PERIOD_W-1:0] dvs;
  } div_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] bin_p;
    logic [PERIOD_W-1:0] bin_f;
    logic [BCD_W-1:0]    bcd_p;
    logic [BCD_W-1:0]    bcd_f;
    logic                sat;
  } bcd_t;

  // one double-dabble step: correct each digit, then shift in one binary bit
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

endpackage

### rtl/period_to_frequency_decimal_readout.sv
// Period count in, ten ASCII digits out: five of the period, then five of
// reference_hz / period_count (clamped to 65535 and flagged saturated when the
// count is zero or the quotient does not fit). An item runs through 26
// restoring-division cells and 16 binary-to-BCD cells, then the serializer;
// the output gives one character per cycle while out_ready is high, and the
// next item loads as the last character of the one before is taken. The
// cell chain holds up to 42 items in flight and stalls as a whole while the
// output side is full. Write reference_hz only while the block is idle.
module period_to_frequency_decimal_readout
  import p2f_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                reference_hz_we,
  input  logic [REF_W-1:0]    reference_hz_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PERIOD_W-1:0] period_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   ascii_char,
  output logic                is_frequency,
  output logic                saturated,
  output logic                last_char
);

  logic [REF_W-1:0] reference_hz;
  logic             en;
  logic             ser_ready;
  logic             div_v [0:REF_W];
  div_t             div_d [0:REF_W];
  logic             bcd_v [0:PERIOD_W];
  bcd_t             bcd_d [0:PERIOD_W];
  logic             quo_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_hz <= REF_RESET;
    end else if (reference_hz_we) begin
      reference_hz <= reference_hz_wdata;
    end
  end

  // whole chain moves together when the last cell can hand off
  assign en       = !bcd_v[PERIOD_W] || ser_ready;
  assign in_ready = en;

  always_comb begin
    div_v[0]     = in_valid;
    div_d[0].dvd = reference_hz;
    div_d[0].quo = '0;
    div_d[0].rem = '0;
    div_d[0].dvs = period_count;
  end

  for (genvar i = 0; i < REF_W; i++) begin : g_div
    p2f_div_cell u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (div_v[i]),
      .in_data   (div_d[i]),
      .out_valid (div_v[i+1]),
      .out_data  (div_d[i+1])
    );
  end

  // a zero divisor yields an all-ones quotient, so it saturates here too
  assign quo_sat = |div_d[REF_W].quo[REF_W-1:PERIOD_W];

  always_comb begin
    bcd_v[0]       = div_v[REF_W];
    bcd_d[0].bin_p = div_d[REF_W].dvs;
    bcd_d[0].bin_f = quo_sat ? FREQ_MAX : div_d[REF_W].quo[PERIOD_W-1:0];
    bcd_d[0].bcd_p = '0;
    bcd_d[0].bcd_f = '0;
    bcd_d[0].sat   = quo_sat;
  end

  for (genvar j = 0; j < PERIOD_W; j++) begin : g_bcd
    p2f_bcd_cell u_bcd (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (bcd_v[j]),
      .in_data   (bcd_d[j]),
      .out_valid (bcd_v[j+1]),
      .out_data  (bcd_d[j+1])
    );
  end

  p2f_serializer u_ser (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (bcd_v[PERIOD_W]),
    .in_ready     (ser_ready),
    .in_data      (bcd_d[PERIOD_W]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ascii_char   (ascii_char),
    .is_frequency (is_frequency),
    .saturated    (saturated),
    .last_char    (last_char)
  );

endmodule

### rtl/p2f_div_cell.sv
module p2f_div_cell
  import p2f_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  div_t in_data,
  output logic out_valid,
  output div_t out_data
);

  logic [PERIOD_W:0] shifted;
  logic [PERIOD_W:0] diff;
  logic              ge;
  div_t              data_next;

  always_comb begin
    shifted = {in_data.rem, in_data.dvd[REF_W-1]};
    diff    = shifted - {1'b0, in_data.dvs};
    ge      = (shifted >= {1'b0, in_data.dvs});
    data_next.dvd = {in_data.dvd[REF_W-2:0], 1'b0};
    data_next.quo = {in_data.quo[REF_W-2:0], ge};
    data_next.rem = ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
    data_next.dvs = in_data.dvs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/p2f_bcd_cell.sv
module p2f_bcd_cell
  import p2f_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  bcd_t in_data,
  output logic out_valid,
  output bcd_t out_data
);

  bcd_t data_next;

  always_comb begin
    data_next.bin_p = {in_data.bin_p[PERIOD_W-2:0], 1'b0};
    data_next.bin_f = {in_data.bin_f[PERIOD_W-2:0], 1'b0};
    data_next.bcd_p = dabble_step(in_data.bcd_p, in_data.bin_p[PERIOD_W-1]);
    data_next.bcd_f = dabble_step(in_data.bcd_f, in_data.bin_f[PERIOD_W-1]);
    data_next.sat   = in_data.sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/p2f_serializer.sv
module p2f_serializer
  import p2f_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bcd_t              in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] ascii_char,
  output logic              is_frequency,
  output logic              saturated,
  output logic              last_char
);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [2*BCD_W-1:0]   digs;
  logic                 sat;
  logic                 xfer;
  logic                 load;

  assign last_char    = (cnt == CNT_W'(NCHARS - 1));
  assign xfer         = busy && out_ready;
  assign in_ready     = !busy || (out_ready && last_char);
  assign load         = in_valid && in_ready;
  assign out_valid    = busy;
  assign ascii_char   = ASCII_ZERO + {2'b00, digs[2*BCD_W-1 -: 4]};
  assign is_frequency = (cnt >= CNT_W'(DIGITS));
  assign saturated    = sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (xfer) begin
      if (last_char) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digs <= {in_data.bcd_p, in_data.bcd_f};
      sat  <= in_data.sat;
    end else if (xfer) begin
      digs <= {digs[2*BCD_W-5:0], 4'b0000};
    end
  end

endmodule

### dv/period_to_frequency_decimal_readout_test.sv
`timescale 1ns / 100ps

module period_to_frequency_decimal_readout_test;
  import p2f_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_freq;
    logic              sat;
    logic              last;
  } readout_char_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                reference_hz_we = 1'b0;
  logic [REF_W-1:0]    reference_hz_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [PERIOD_W-1:0] period_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHAR_W-1:0]   ascii_char;
  logic                is_frequency;
  logic                saturated;
  logic                last_char;

  logic [PERIOD_W-1:0] pending_periods[$];
  readout_char_t       expected_chars[$];
  logic [REF_W-1:0]    ref_hz_model = REF_RESET;

  int failures = 0;
  int periods_sent = 0;
  int chars_checked = 0;
  int settings_used = 1;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int cycle_count = 0;
  logic ready_next;
  logic char_bad;
  readout_char_t want;

  period_to_frequency_decimal_readout DUT (
    .clk                (clk),
    .rst                (rst),
    .reference_hz_we    (reference_hz_we),
    .reference_hz_wdata (reference_hz_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .period_count       (period_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .ascii_char         (ascii_char),
    .is_frequency       (is_frequency),
    .saturated          (saturated),
    .last_char          (last_char)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ten characters per period: period digits, then frequency digits
  function automatic void predict_readout(input logic [PERIOD_W-1:0] p);
    int unsigned freq;
    int unsigned digit_src;
    int unsigned pw;
    logic sat;
    readout_char_t c;
    sat = 1'b0;
    if (p == '0) begin
      freq = FREQ_MAX;
      sat = 1'b1;
    end else begin
      freq = 32'(ref_hz_model) / 32'(p);
      if (freq > FREQ_MAX) begin
        freq = FREQ_MAX;
        sat = 1'b1;
      end
    end
    for (int k = 0; k < NCHARS; k++) begin
      digit_src = (k < DIGITS) ? 32'(p) : freq;
      pw = 1;
      for (int j = 0; j < DIGITS - 1 - (k % DIGITS); j++) pw = pw * 10;
      c.ch = ASCII_ZERO + CHAR_W'((digit_src / pw) % 10);
      c.is_freq = (k >= DIGITS);
      c.sat = sat;
      c.last = (k == NCHARS - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period(input logic [REF_W-1:0] r);
    int unsigned edge_p;
    int unsigned lo;
    int unsigned hi;
    edge_p = 32'(r) / FREQ_MAX;
    case ($urandom_range(0, 9))
      5: return PERIOD_W'($urandom_range(0, 64));
      6: begin
        lo = (edge_p > 3) ? edge_p - 3 : 0;
        hi = (edge_p + 3 > FREQ_MAX) ? FREQ_MAX : edge_p + 3;
        return PERIOD_W'($urandom_range(lo, hi));
      end
      7: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return PERIOD_W'(1);
          2: return '1;
          default: return PERIOD_W'(FREQ_MAX - 1);
        endcase
      end
      default: return PERIOD_W'($urandom);
    endcase
  endfunction

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_readout(period_count);
        periods_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_periods.size() > 0) begin
          period_count <= pending_periods.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each character transfer, stall out_ready on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          $error("unexpected character transfer: ascii_char %0d", ascii_char);
          failures++;
        end else begin
          want = expected_chars.pop_front();
          char_bad = 1'b0;
          if (ascii_char !== want.ch) begin
            $error("ascii_char expected %0d actual %0d", want.ch, ascii_char);
            char_bad = 1'b1;
          end
          if (is_frequency !== want.is_freq) begin
            $error("is_frequency expected %0d actual %0d", want.is_freq, is_frequency);
            char_bad = 1'b1;
          end
          if (saturated !== want.sat) begin
            $error("saturated expected %0d actual %0d", want.sat, saturated);
            char_bad = 1'b1;
          end
          if (last_char !== want.last) begin
            $error("last_char expected %0d actual %0d", want.last, last_char);
            char_bad = 1'b1;
          end
          if (char_bad) failures++;
        end
      end
      cycle_count++;
      if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 2);
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        case (stall_mode)
          1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(4, 15);
          default: ;
        endcase
      end
      out_ready <= ready_next;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_periods.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reference(input logic [REF_W-1:0] v);
    @(posedge clk);
    reference_hz_we <= 1'b1;
    reference_hz_wdata <= v;
    ref_hz_model = v;
    @(posedge clk);
    reference_hz_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) pending_periods.push_back(pick_period(ref_hz_model));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset value of the reference clock
    pending_periods.push_back(16'd0);
    pending_periods.push_back(16'd1);
    pending_periods.push_back(16'hFFFF);
    pending_periods.push_back(16'hFFFE);
    pending_periods.push_back(16'd244);
    pending_periods.push_back(16'd245);
    pending_periods.push_back(16'h5555);
    pending_periods.push_back(16'hAAAA);
    pending_periods.push_back(16'd12345);
    pending_periods.push_back(16'd10000);
    pending_periods.push_back(16'd9999);
    queue_random(100);
    wait_idle();

    // largest reference: quotient of exactly 65535 at 1024
    write_reference('1);
    pending_periods.push_back(16'd1023);
    pending_periods.push_back(16'd1024);
    pending_periods.push_back(16'd1025);
    pending_periods.push_back(16'hFFFF);
    queue_random(100);
    wait_idle();

    write_reference(REF_W'(1));
    pending_periods.push_back(16'd1);
    pending_periods.push_back(16'd2);
    pending_periods.push_back(16'd0);
    queue_random(40);
    wait_idle();

    // zero reference gives zero frequency for any nonzero period
    write_reference('0);
    pending_periods.push_back(16'd7);
    pending_periods.push_back(16'd0);
    queue_random(40);
    wait_idle();

    write_reference(REF_W'($urandom_range(1, 67108863)));
    queue_random(60);
    wait_idle();

    write_reference(REF_W'($urandom_range(1000, 2000000)));
    queue_random(60);
    wait_idle();

    write_reference(REF_RESET);
    queue_random(40);
    wait_idle();

    $display("%0d periods sent under %0d reference settings, %0d characters checked",
             periods_sent, settings_used, chars_checked);
    $display("random bursts and output stalls mixed in throughout");
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the readout to drain");
    $display("Test completed with failures");
    $finish;
  end

endmodule
